// ===== hw/rtl/ohs_pkg.sv =====
// Shared constants, types and control structs of the open addressing hash set.
`timescale 1ns / 1ps

package ohs_pkg;

    // Table geometry
    localparam int TABLE_SLOTS = 1024;
    localparam int KEY_BYTES   = 8;
    localparam int IDX_W       = $clog2(TABLE_SLOTS);
    localparam int KEY_W       = 64;
    localparam int BIDX_W      = 3;
    localparam int CNT_W       = 11;
    localparam int OUT_W       = 16;

    // Hash constants
    localparam logic [KEY_W-1:0] HASH_SEED  = 64'd5381;
    localparam logic [KEY_W-1:0] HASH_PRIME = 64'hFFFF_FFFF_FFFF_FFC5;

    // Used key bits; an all-ones key under this mask marks a tombstone
    localparam logic [KEY_W-1:0] KEY_MASK =
        (KEY_BYTES >= 8) ? {KEY_W{1'b1}}
                         : KEY_W'((65'd1 << (8 * KEY_BYTES)) - 65'd1);

    localparam logic [BIDX_W-1:0] LAST_BYTE = BIDX_W'(KEY_BYTES - 1);
    localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(TABLE_SLOTS - 1);

    // Operation codes
    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_DEL = 2'd1,
        CMD_QRY = 2'd2,
        CMD_NOP = 2'd3
    } t_cmd;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic hash_en;
        logic reduce;
        logic probe_rd;
        logic probe_eval;
        logic finish;
        logic clr_en;
    } t_dp_ctl;

    // Datapath to controller status
    typedef struct packed {
        logic skip;
        logic hash_last;
        logic hit;
        logic empty;
        logic bound_last;
        logic clr_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== hw/rtl/open_addressing_hash_set.sv =====
// Top level of the open addressing hash set with double hashing.
//
//  channel | direction | word contents (lowest bit first)
//  --------+-----------+------------------------------------------------
//  s       | in        | tuser: cmd[1:0]; tdata: key[63:0]
//  m       | out       | tdata: done_ok, table_full, entry_count[10:0], 3 zero bits
//
// A command runs through hashing of the key one byte at a time, a reduce step, then for
// each probed slot (1 to 1024) a read state and a compare state through the registered
// slot RAM read, and a finish step; marker keys and the unused code skip the probe.
// The next word is accepted in the cycle after the finish.
// After reset a clearing pass writes all 1024 slots to zero with s_tready low.
// A result waits in the output register; finish stalls while an older result is held and not taken.
`timescale 1ns / 1ps

module open_addressing_hash_set (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [ohs_pkg::KEY_W-1:0]   i_s_tdata,   // key[63:0]
    input  logic [1:0]                  i_s_tuser,   // cmd[1:0]
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [ohs_pkg::OUT_W-1:0]   o_m_tdata    // done_ok, table_full, entry_count[10:0]
);

    import ohs_pkg::*;

    t_dp_ctl ctl;
    t_dp_sts sts;

    ohs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    ohs_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .o_sts      (sts),
        .i_cmd      (i_s_tuser),
        .i_key      (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

// ===== hw/rtl/ohs_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module ohs_ram #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ohs_ctrl.sv =====
// Controller state machine: clearing pass, hashing, probing and finish.
`timescale 1ns / 1ps

module ohs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  ohs_pkg::t_dp_sts i_sts,
    output ohs_pkg::t_dp_ctl o_ctl
);

    import ohs_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_REDUCE,
        ST_PROBE_RD,
        ST_PROBE_CMP,
        ST_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_s_tvalid) n_state = ST_HASH;
            end
            ST_HASH: begin
                if (i_sts.hash_last) n_state = ST_REDUCE;
            end
            ST_REDUCE: begin
                n_state = i_sts.skip ? ST_FIN : ST_PROBE_RD;
            end
            ST_PROBE_RD: begin
                n_state = ST_PROBE_CMP;
            end
            ST_PROBE_CMP: begin
                if (i_sts.hit || i_sts.empty || i_sts.bound_last) n_state = ST_FIN;
                else n_state = ST_PROBE_RD;
            end
            ST_FIN: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // command decode
    assign o_s_tready       = (r_state == ST_IDLE);
    assign o_ctl.load       = (r_state == ST_IDLE) && i_s_tvalid;
    assign o_ctl.hash_en    = (r_state == ST_HASH);
    assign o_ctl.reduce     = (r_state == ST_REDUCE);
    assign o_ctl.probe_rd   = (r_state == ST_PROBE_RD);
    assign o_ctl.probe_eval = (r_state == ST_PROBE_CMP);
    assign o_ctl.finish     = (r_state == ST_FIN) && i_sts.out_free;
    assign o_ctl.clr_en     = (r_state == ST_CLEAR);

endmodule

// ===== hw/rtl/ohs_dp.sv =====
// Datapath: key hashing, probe position, slot store, count and result word.
`timescale 1ns / 1ps

module ohs_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ohs_pkg::t_dp_ctl            i_ctl,
    output ohs_pkg::t_dp_sts            o_sts,
    input  logic [1:0]                  i_cmd,
    input  logic [ohs_pkg::KEY_W-1:0]   i_key,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [ohs_pkg::OUT_W-1:0]   o_m_tdata
);

    import ohs_pkg::*;

    // operation registers
    t_cmd              r_cmd;
    logic [KEY_W-1:0]  r_key;
    logic [KEY_W-1:0]  r_hash;
    logic [KEY_W-1:0]  r_step;
    logic [BIDX_W-1:0] r_byte_idx;

    // probe registers
    logic [IDX_W-1:0]  r_pos;
    logic [IDX_W-1:0]  r_step_lo;
    logic [IDX_W-1:0]  r_probe_n;
    logic [IDX_W-1:0]  r_free_pos;
    logic              r_found;
    logic              r_have_empty;
    logic              r_have_free;

    // store and result
    logic [IDX_W-1:0]  r_clr_addr;
    logic [CNT_W-1:0]  r_count;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;

    logic [7:0]        hash_byte;
    logic [KEY_W-1:0]  byte_sx;
    logic [KEY_W-1:0]  hash_red;
    logic [KEY_W-1:0]  slot_rdata;
    logic [KEY_W-1:0]  slot_val;
    logic              skip;
    logic              add_wr;
    logic              del_wr;
    logic              res_ok;
    logic              res_full;
    logic [CNT_W-1:0]  count_nxt;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [KEY_W-1:0]  ram_wdata;

    // byte feed for the hash and step accumulators
    assign hash_byte = r_key[8*r_byte_idx +: 8];
    assign byte_sx   = {{(KEY_W-8){hash_byte[7]}}, hash_byte};

    // reduce modulo the prime: one subtract suffices below 2^64
    assign hash_red = (r_hash >= HASH_PRIME) ? (r_hash - HASH_PRIME) : r_hash;

    // marker keys and the unused code change nothing
    assign skip = (r_cmd == CMD_NOP) || (r_key == '0) || (r_key == KEY_MASK);

    assign slot_val = slot_rdata & KEY_MASK;

    // finish decisions
    assign add_wr   = !skip && (r_cmd == CMD_ADD) && !r_found && (r_have_free || r_have_empty);
    assign del_wr   = !skip && (r_cmd == CMD_DEL) && r_found;
    assign res_ok   = add_wr || del_wr || (!skip && (r_cmd == CMD_QRY) && r_found);
    assign res_full = !skip && !r_found && !r_have_empty && !r_have_free;

    always_comb begin
        count_nxt = r_count;
        if (add_wr) begin
            count_nxt = r_count + CNT_W'(1);
        end else if (del_wr && (r_count != '0)) begin
            count_nxt = r_count - CNT_W'(1);
        end
    end

    // store write port: clearing pass or finish update
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = r_key;
        if (i_ctl.clr_en) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if (i_ctl.finish && add_wr) begin
            ram_we    = 1'b1;
            ram_waddr = r_have_free ? r_free_pos : r_pos;
            ram_wdata = r_key;
        end else if (i_ctl.finish && del_wr) begin
            ram_we    = 1'b1;
            ram_waddr = r_pos;
            ram_wdata = KEY_MASK;
        end
    end

    ohs_ram #(
        .DATA_W (KEY_W),
        .DEPTH  (TABLE_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_ctl.probe_rd),
        .i_raddr (r_pos),
        .o_rdata (slot_rdata)
    );

    // hashing and probe payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd        <= t_cmd'(i_cmd);
            r_key        <= i_key & KEY_MASK;
            r_hash       <= HASH_SEED;
            r_step       <= '0;
            r_byte_idx   <= '0;
            r_probe_n    <= '0;
            r_found      <= 1'b0;
            r_have_empty <= 1'b0;
            r_have_free  <= 1'b0;
        end
        if (i_ctl.hash_en) begin
            r_hash     <= (r_hash << 5) + r_hash + byte_sx;
            r_step     <= (r_step << 2) + r_step + byte_sx;
            r_byte_idx <= r_byte_idx + BIDX_W'(1);
        end
        if (i_ctl.reduce) begin
            r_pos     <= hash_red[IDX_W-1:0];
            r_step_lo <= r_step[IDX_W-1:0];
        end
        if (i_ctl.probe_eval) begin
            if (slot_val == r_key) begin
                r_found <= 1'b1;
            end else if (slot_val == '0) begin
                r_have_empty <= 1'b1;
            end else begin
                if ((slot_val == KEY_MASK) && !r_have_free) begin
                    r_have_free <= 1'b1;
                    r_free_pos  <= r_pos;
                end
                r_pos     <= r_pos + r_step_lo;
                r_probe_n <= r_probe_n + IDX_W'(1);
            end
        end
    end

    // control registers: clear sweep, count, result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.clr_en) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
            if (i_ctl.finish) begin
                r_count     <= count_nxt;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            r_out_data <= OUT_W'({count_nxt, res_full, res_ok});
        end
    end

    // status to controller
    assign o_sts.skip       = skip;
    assign o_sts.hash_last  = (r_byte_idx == LAST_BYTE);
    assign o_sts.hit        = (slot_val == r_key);
    assign o_sts.empty      = (slot_val == '0);
    assign o_sts.bound_last = (r_probe_n == LAST_SLOT);
    assign o_sts.clr_last   = (r_clr_addr == LAST_SLOT);
    assign o_sts.out_free   = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
